// File: design/ranked_key_table_lookup_assert.svh
// Assertion macros shared by the ranked key table lookup RTL.
// Included by the controller and the datapath; no other dependencies.
`ifndef RANKED_KEY_TABLE_LOOKUP_ASSERT_SVH
`define RANKED_KEY_TABLE_LOOKUP_ASSERT_SVH

// Same-cycle implication.
`define RKTL_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rktl: same-cycle check failed");

// Next-cycle implication.
`define RKTL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rktl: next-cycle check failed");

`endif

// File: design/rktl_pkg.sv
// Shared types and constants for the ranked key table lookup.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rktl_pkg;

   localparam int MAX_ROWS_DEF = 1024;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ANY_VERSION = 1'd1;

   localparam logic [10:0] ROW_COUNT_RST   = 11'd0;
   localparam logic [7:0]  ANY_VERSION_RST = 8'hFF;
   localparam logic [7:0]  WILD_CHAR       = 8'h3F;   // '?'

   localparam logic [2:0] RANK_NONE      = 3'd0;
   localparam logic [2:0] RANK_WILD_ANY  = 3'd1;
   localparam logic [2:0] RANK_EXACT_ANY = 3'd2;
   localparam logic [2:0] RANK_WILD_VER  = 3'd3;
   localparam logic [2:0] RANK_EXACT_VER = 3'd4;
   localparam logic [2:0] RANK_KEY       = 3'd5;

   typedef struct packed {
      logic        mode;
      logic [9:0]  row_index;
      logic [63:0] key_sum;
      logic [31:0] title_code;
      logic [7:0]  version;
      logic        has_title_code;
      logic [15:0] entry_count;
      logic [31:0] cheats_offset;
      logic [31:0] data_size;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [9:0]  hit_index;
      logic [2:0]  match_rank;
      logic [15:0] hit_count;
      logic [31:0] hit_offset;
      logic [31:0] hit_size;
   } rsp_type;

   typedef struct packed {
      logic [63:0] key;
      logic [31:0] code;
      logic [7:0]  version;
      logic [15:0] count;
      logic [31:0] offset;
      logic [31:0] size;
   } row_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic load_wr;
      logic start;
      logic srch_issue;
      logic srch_cmp;
      logic scan_step;
      logic load_out;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic n_zero;
      logic key_zero;
      logic has_code;
      logic srch_open;
      logic srch_eq;
      logic scan_done;
   } sts_type;

endpackage

// File: design/rktl_dpath.sv
// Datapath: row memory, config registers, binary search bounds, scan pipeline,
// best-match tracking and result register. Depends on rktl_pkg.
`timescale 1ns / 1ps
`include "ranked_key_table_lookup_assert.svh"

module rktl_dpath import rktl_pkg::*; #(
   parameter int MAX_ROWS = MAX_ROWS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  req_type               req_payload,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  cmd_type               cmd,
   output sts_type               sts,
   output rsp_type               rsp_payload
);

   localparam int AW = $clog2(MAX_ROWS);
   localparam int NW = $clog2(MAX_ROWS + 1);

   row_type row_mem [MAX_ROWS];

   logic [10:0]   row_count_ff;
   logic [7:0]    any_ver_ff;
   logic [63:0]   key_ff;
   logic [31:0]   code_ff;
   logic [7:0]    ver_ff;
   logic          has_code_ff;
   logic [NW-1:0] lo_ff;
   logic [NW-1:0] bound_ff;      // one past the upper search bound
   logic [AW-1:0] mid_ff;
   logic [NW-1:0] scan_idx_ff;
   logic          cmp_valid_ff;
   logic [AW-1:0] cmp_idx_ff;
   row_type       rd_row_ff;
   logic [2:0]    best_rank_ff;
   logic [AW-1:0] best_idx_ff;
   logic [15:0]   best_count_ff;
   logic [31:0]   best_offset_ff;
   logic [31:0]   best_size_ff;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;

   logic [NW-1:0] n_rows;
   logic [NW-1:0] span;
   logic [NW-1:0] mid_full;
   logic          scan_issue;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   row_type       wr_row;
   logic          wild;
   logic [31:0]   code_mask;
   logic          code_hit;
   logic [2:0]    scan_rank;
   logic          scan_upd;
   logic          srch_eq;

   always_comb begin
      if ({21'd0, row_count_ff} > 32'(MAX_ROWS)) begin
         n_rows = NW'(MAX_ROWS);
      end else begin
         n_rows = NW'(row_count_ff);
      end
   end

   // lo + (hi - lo) / 2 with hi = bound - 1; only used while lo < bound
   assign span     = bound_ff - lo_ff - NW'(1);
   assign mid_full = lo_ff + (span >> 1);

   assign scan_issue = cmd.scan_step && (scan_idx_ff < n_rows);
   assign rd_en      = cmd.srch_issue || scan_issue;
   assign rd_addr    = cmd.srch_issue ? mid_full[AW-1:0] : scan_idx_ff[AW-1:0];

   assign wr_en  = cmd.load_wr && ({22'd0, req_payload.row_index} < 32'(MAX_ROWS));
   assign wr_row = '{key:     req_payload.key_sum,
                     code:    req_payload.title_code,
                     version: req_payload.version,
                     count:   req_payload.entry_count,
                     offset:  req_payload.cheats_offset,
                     size:    req_payload.data_size};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[AW'(req_payload.row_index)] <= wr_row;
      end
      if (rd_en) begin
         rd_row_ff <= row_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= ROW_COUNT_RST;
         any_ver_ff   <= ANY_VERSION_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ROW_COUNT:   row_count_ff <= csr_data;
            CSR_ANY_VERSION: any_ver_ff   <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         key_ff      <= req_payload.key_sum;
         code_ff     <= req_payload.title_code;
         ver_ff      <= req_payload.version;
         has_code_ff <= req_payload.has_title_code;
      end
   end

   assign srch_eq = (rd_row_ff.key == key_ff);

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         lo_ff    <= '0;
         bound_ff <= n_rows;
      end else if (cmd.srch_cmp && !srch_eq) begin
         if (rd_row_ff.key < key_ff) begin
            lo_ff <= NW'(mid_ff) + NW'(1);
         end else begin
            bound_ff <= NW'(mid_ff);
         end
      end
      if (cmd.srch_issue) begin
         mid_ff <= mid_full[AW-1:0];
      end
   end

   // scan: the address goes out first, and the row is ranked in the cycle after
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff  <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         if (cmd.start) begin
            scan_idx_ff <= '0;
         end else if (scan_issue) begin
            scan_idx_ff <= scan_idx_ff + NW'(1);
         end
         cmp_valid_ff <= scan_issue;
      end
      if (scan_issue) begin
         cmp_idx_ff <= scan_idx_ff[AW-1:0];
      end
   end

   always_comb begin
      wild      = (rd_row_ff.code[7:0] == WILD_CHAR);
      code_mask = wild ? 32'hFFFF_FF00 : 32'hFFFF_FFFF;
      code_hit  = (((rd_row_ff.code ^ code_ff) & code_mask) == 32'd0);
      if (rd_row_ff.version == ver_ff) begin
         scan_rank = wild ? RANK_WILD_VER : RANK_EXACT_VER;
      end else if (rd_row_ff.version == any_ver_ff) begin
         scan_rank = wild ? RANK_WILD_ANY : RANK_EXACT_ANY;
      end else begin
         scan_rank = RANK_NONE;
      end
      // strict compare keeps the first row of the top rank
      scan_upd = cmp_valid_ff && code_hit && (scan_rank > best_rank_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_rank_ff <= RANK_NONE;
      end else if (cmd.start) begin
         best_rank_ff <= RANK_NONE;
      end else if (cmd.srch_cmp && srch_eq) begin
         best_rank_ff <= RANK_KEY;
      end else if (scan_upd) begin
         best_rank_ff <= scan_rank;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         best_idx_ff    <= '0;
         best_count_ff  <= '0;
         best_offset_ff <= '0;
         best_size_ff   <= '0;
      end else if ((cmd.srch_cmp && srch_eq) || scan_upd) begin
         best_idx_ff    <= cmd.srch_cmp ? mid_ff : cmp_idx_ff;
         best_count_ff  <= rd_row_ff.count;
         best_offset_ff <= rd_row_ff.offset;
         best_size_ff   <= rd_row_ff.size;
      end
   end

   always_comb begin
      rsp_in.found      = (best_rank_ff != RANK_NONE);
      rsp_in.hit_index  = 10'(best_idx_ff);
      rsp_in.match_rank = best_rank_ff;
      rsp_in.hit_count  = best_count_ff;
      rsp_in.hit_offset = best_offset_ff;
      rsp_in.hit_size   = best_size_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

   assign sts.n_zero    = (n_rows == '0);
   assign sts.key_zero  = (key_ff == 64'd0);
   assign sts.has_code  = has_code_ff;
   assign sts.srch_open = (lo_ff < bound_ff);
   assign sts.srch_eq   = srch_eq;
   assign sts.scan_done = (scan_idx_ff == n_rows) && !cmp_valid_ff;

   `RKTL_ASSERT_NEXT(a_key_hit_rank, clock, reset, cmd.srch_cmp && srch_eq,
                     best_rank_ff == RANK_KEY)
   `RKTL_ASSERT_NOW(a_scan_bound, clock, reset, cmd.scan_step, scan_idx_ff <= n_rows)
   `RKTL_ASSERT_NOW(a_cmp_in_range, clock, reset, cmp_valid_ff, NW'(cmp_idx_ff) < n_rows)

endmodule

// File: design/rktl_ctrl.sv
// Controller FSM: sequences load, binary search, code scan and result hand-off.
// Depends on rktl_pkg; drives the datapath through cmd_type / sts_type.
`timescale 1ns / 1ps
`include "ranked_key_table_lookup_assert.svh"

module rktl_ctrl import rktl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_mode,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_START    = 3'd1;
   localparam logic [2:0] ST_SRCH     = 3'd2;
   localparam logic [2:0] ST_SRCH_CMP = 3'd3;
   localparam logic [2:0] ST_SCAN     = 3'd4;
   localparam logic [2:0] ST_FINISH   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       req_acc;
   logic       out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_acc && req_mode;
            cmd.load_wr = req_acc && !req_mode;
            if (req_acc && req_mode) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            cmd.start = 1'b1;
            if (sts.n_zero) begin
               state_in = ST_FINISH;
            end else if (!sts.key_zero) begin
               state_in = ST_SRCH;
            end else if (sts.has_code) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SRCH: begin
            if (sts.srch_open) begin
               cmd.srch_issue = 1'b1;
               state_in       = ST_SRCH_CMP;
            end else if (sts.has_code) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SRCH_CMP: begin
            cmd.srch_cmp = 1'b1;
            state_in     = sts.srch_eq ? ST_FINISH : ST_SRCH;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `RKTL_ASSERT_NEXT(a_query_starts, clock, reset, req_acc && req_mode, state_ff == ST_START)
   `RKTL_ASSERT_NEXT(a_load_stays_idle, clock, reset, req_acc && !req_mode,
                     state_ff == ST_IDLE)
   `RKTL_ASSERT_NOW(a_cmp_after_issue, clock, reset, state_ff == ST_SRCH_CMP,
                    $past(state_ff) == ST_SRCH)

endmodule

// File: design/ranked_key_table_lookup.sv
// Ranked key table lookup: a load is written in its accept cycle, loads can go back to back.
// A query is accepted and set up, then runs binary-search probes (at most clog2(n)+1
// probes, one memory read port), closes a missed search, runs the code scan
// when needed, and moves the item into the output register (stalls while it is full).
// One query in flight at a time.
// Reset clears control and config registers; table rows are undefined until loaded.
`timescale 1ns / 1ps

module ranked_key_table_lookup import rktl_pkg::*; #(
   parameter int MAX_ROWS = MAX_ROWS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   // config writes are to land only while idle (the block itself does not enforce it); they are never stalled
   assign csr_ready = 1'b1;

   rktl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_payload.mode),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rktl_dpath #(
      .MAX_ROWS (MAX_ROWS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_valid   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: tb/ranked_key_table_lookup_test.sv
// Self-checking bench for ranked_key_table_lookup: loads tables, runs lookup queries and
// checks every answer against a shadow of the table and of the search/scan ranking.
// Depends on rktl_pkg and the ranked_key_table_lookup RTL only.
`timescale 1ns / 1ps

module ranked_key_table_lookup_test;
   import rktl_pkg::*;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;
   localparam int   STALL_LIMIT = 8000;
   localparam int   CHOKE_CYCLES = 400;
   localparam int   ITEM_TARGET = 570;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // shadow of the block
   row_type     shadow_rows [MAX_ROWS_DEF];
   logic [10:0] shadow_row_count = ROW_COUNT_RST;
   logic [7:0]  shadow_any_ver = ANY_VERSION_RST;

   req_type req_backlog [$];
   rsp_type answers_due [$];

   // stimulus side view of the table, used to aim queries at stored keys
   logic [63:0] staged_key [MAX_ROWS_DEF];
   logic [23:0] code_stem [3];
   logic [7:0]  code_tail [3];
   logic [7:0]  ver_pool [2];
   logic [7:0]  gen_any_ver = ANY_VERSION_RST;

   int  items_pushed = 0;
   int  items_taken = 0;
   int  answers_seen = 0;
   int  mismatches = 0;
   int  quiet_cycles = 0;
   int  req_gap = 0, req_run = 0;
   bit  req_no_idle = 1'b0;
   int  rsp_hold = 0, rsp_run = 0;
   bit  rsp_no_idle = 1'b0;
   logic choke = 1'b0;
   int  choke_left = 0;
   bit  choke_done = 1'b0;

   ranked_key_table_lookup dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic logic [63:0] wide_rand();
      return {$urandom, $urandom};
   endfunction

   // per-item wait, with runs of items that have no wait at all
   function automatic int draw_gap(inout int run_left, inout bit no_idle);
      if (run_left == 0) begin
         run_left = $urandom_range(8, 48);
         no_idle = ($urandom_range(0, 3) == 0);
      end
      run_left--;
      return no_idle ? 0 : $urandom_range(0, 7);
   endfunction

   function automatic rsp_type hit_answer(logic [2:0] rank, int idx);
      rsp_type r;
      r.found = 1'b1;
      r.hit_index = 10'(idx);
      r.match_rank = rank;
      r.hit_count = shadow_rows[idx].count;
      r.hit_offset = shadow_rows[idx].offset;
      r.hit_size = shadow_rows[idx].size;
      return r;
   endfunction

   function automatic rsp_type rank_lookup(req_type q);
      rsp_type     r;
      int          n, lo, hi, mid, best_i;
      logic [2:0]  best, rank;
      logic        wild;
      logic [31:0] mask;
      r = '0;
      n = (shadow_row_count > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(shadow_row_count);
      if (n == 0) return r;
      if (q.key_sum != 64'd0) begin
         lo = 0;
         hi = n - 1;
         while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (shadow_rows[mid].key == q.key_sum) return hit_answer(RANK_KEY, mid);
            if (shadow_rows[mid].key < q.key_sum) lo = mid + 1;
            else hi = mid - 1;
         end
      end
      if (!q.has_title_code) return r;
      best = RANK_NONE;
      best_i = 0;
      for (int i = 0; i < n; i++) begin
         wild = (shadow_rows[i].code[7:0] == WILD_CHAR);
         mask = wild ? 32'hFFFF_FF00 : 32'hFFFF_FFFF;
         if (((shadow_rows[i].code ^ q.title_code) & mask) != 32'd0) continue;
         if (shadow_rows[i].version == q.version) rank = wild ? RANK_WILD_VER : RANK_EXACT_VER;
         else if (shadow_rows[i].version == shadow_any_ver)
            rank = wild ? RANK_WILD_ANY : RANK_EXACT_ANY;
         else continue;
         // strictly greater: the first row at the top rank keeps it
         if (rank > best) begin
            best = rank;
            best_i = i;
         end
      end
      if (best != RANK_NONE) r = hit_answer(best, best_i);
      return r;
   endfunction

   function automatic void report_field(string fname, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h got %0h", $time, fname, want, got);
         mismatches++;
      end
   endfunction

   task automatic offer_load(logic [9:0] idx, logic [63:0] key, logic [31:0] code,
                             logic [7:0] ver, logic [15:0] cnt, logic [31:0] off,
                             logic [31:0] len);
      req_type it;
      it.mode = MODE_LOAD;
      it.row_index = idx;
      it.key_sum = key;
      it.title_code = code;
      it.version = ver;
      it.has_title_code = 1'($urandom);
      it.entry_count = cnt;
      it.cheats_offset = off;
      it.data_size = len;
      staged_key[idx] = key;
      req_backlog.push_back(it);
      items_pushed++;
   endtask

   task automatic offer_query(logic [63:0] key, logic [31:0] code, logic [7:0] ver,
                              logic has_code);
      req_type it;
      it.mode = MODE_QUERY;
      it.row_index = 10'($urandom);
      it.key_sum = key;
      it.title_code = code;
      it.version = ver;
      it.has_title_code = has_code;
      it.entry_count = 16'($urandom);
      it.cheats_offset = $urandom;
      it.data_size = $urandom;
      req_backlog.push_back(it);
      items_pushed++;
   endtask

   // wait until every item is in and answered, then let the block go quiet
   task automatic settle();
      while (items_taken != items_pushed || answers_due.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_ROW_COUNT:   shadow_row_count = val;
         CSR_ANY_VERSION: shadow_any_ver = val[7:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic table_phase(logic [10:0] rows_cfg, int queries, bit refill);
      int          n, pick;
      bit          shuffled;
      logic [63:0] step, key;
      logic [31:0] code;
      logic [7:0]  ver;
      n = (rows_cfg > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(rows_cfg);
      settle();
      write_csr(CSR_ROW_COUNT, rows_cfg);
      case ($urandom_range(0, 3))
         0: gen_any_ver = 8'h00;
         1: gen_any_ver = 8'hFF;
         default: gen_any_ver = 8'($urandom);
      endcase
      write_csr(CSR_ANY_VERSION, {3'b000, gen_any_ver});
      @(negedge clock);
      if (refill) begin
         for (int i = 0; i < 3; i++) begin
            code_stem[i] = 24'($urandom);
            code_tail[i] = 8'($urandom);
         end
         ver_pool[0] = 8'($urandom);
         ver_pool[1] = 8'($urandom);
         shuffled = ($urandom_range(0, 7) == 0);
         step = 64'hFFFF_FFFF_FFFF_FFFF / 64'(n + 1);
         key = 64'd0;
         for (int i = 0; i < n; i++) begin
            // ascending keys with the odd duplicate; now and then a scrambled table
            if (shuffled) key = wide_rand();
            else if (i == 0) key = wide_rand() % step;
            else key = key + (($urandom_range(0, 15) == 0) ? 64'd0 : wide_rand() % step);
            code = {code_stem[$urandom_range(0, 2)],
                    ($urandom_range(0, 3) == 0) ? WILD_CHAR : code_tail[$urandom_range(0, 2)]};
            case ($urandom_range(0, 2))
               0: ver = ver_pool[0];
               1: ver = ver_pool[1];
               default: ver = gen_any_ver;
            endcase
            offer_load(10'(i), key, code, ver, 16'($urandom), $urandom, $urandom);
         end
      end
      for (int k = 0; k < queries; k++) begin
         if ($urandom_range(0, 7) == 0)
            offer_load(10'($urandom), wide_rand(), $urandom, 8'($urandom),
                       16'($urandom), $urandom, $urandom);
         pick = $urandom_range(0, 9);
         if (n != 0 && pick < 4) key = staged_key[$urandom_range(0, n - 1)];
         else if (pick < 6) key = 64'd0;
         else key = wide_rand();
         case ($urandom_range(0, 4))
            0: code = $urandom;
            1: code = {code_stem[$urandom_range(0, 2)], 8'($urandom)};
            default: code = {code_stem[$urandom_range(0, 2)], code_tail[$urandom_range(0, 2)]};
         endcase
         case ($urandom_range(0, 3))
            0: ver = ver_pool[0];
            1: ver = ver_pool[1];
            2: ver = gen_any_ver;
            default: ver = 8'($urandom);
         endcase
         offer_query(key, code, ver, $urandom_range(0, 7) != 0);
      end
   endtask

   // row count past the table size; only the rows on the probe paths of the
   // queried keys are loaded, and no query carries a code, so no scan runs
   task automatic clamp_phase();
      int path [11];
      path = '{511, 767, 895, 959, 991, 1007, 1015, 1019, 1021, 1022, 1023};
      settle();
      write_csr(CSR_ROW_COUNT, 11'd2047);
      @(negedge clock);
      for (int i = 0; i < 11; i++)
         offer_load(10'(path[i]), 64'(100 * (i + 1)), $urandom, 8'($urandom),
                    16'($urandom), $urandom, $urandom);
      offer_query(64'd1000, $urandom, 8'($urandom), 1'b0);
      offer_query(64'd1100, $urandom, 8'($urandom), 1'b0);
      offer_query(64'd950, $urandom, 8'($urandom), 1'b0);
      offer_query(64'hFFFF_FFFF_FFFF_FFFF, $urandom, 8'($urandom), 1'b0);
      offer_query(64'd0, $urandom, 8'($urandom), 1'b0);
   endtask

   // driver: accepted items update the shadow table or queue the predicted answer
   always @(posedge clock) begin : feed_items
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            items_taken++;
            if (req_payload.mode == MODE_LOAD) begin
               shadow_rows[req_payload.row_index].key = req_payload.key_sum;
               shadow_rows[req_payload.row_index].code = req_payload.title_code;
               shadow_rows[req_payload.row_index].version = req_payload.version;
               shadow_rows[req_payload.row_index].count = req_payload.entry_count;
               shadow_rows[req_payload.row_index].offset = req_payload.cheats_offset;
               shadow_rows[req_payload.row_index].size = req_payload.data_size;
            end else begin
               answers_due.push_back(rank_lookup(req_payload));
            end
            req_gap = draw_gap(req_run, req_no_idle);
         end
         if (!req_valid || req_ready) begin
            if (req_gap != 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() != 0) begin
               req_payload <= req_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compares answers in order and paces rsp_ready
   always @(posedge clock) begin : watch_answers
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            answers_seen++;
            if (answers_due.size() == 0) begin
               $display("%0t: answer expected none got %h", $time, rsp_payload);
               mismatches++;
            end else begin
               want = answers_due.pop_front();
               report_field("found", 64'(want.found), 64'(rsp_payload.found));
               report_field("hit_index", 64'(want.hit_index), 64'(rsp_payload.hit_index));
               report_field("match_rank", 64'(want.match_rank), 64'(rsp_payload.match_rank));
               report_field("hit_count", 64'(want.hit_count), 64'(rsp_payload.hit_count));
               report_field("hit_offset", 64'(want.hit_offset), 64'(rsp_payload.hit_offset));
               report_field("hit_size", 64'(want.hit_size), 64'(rsp_payload.hit_size));
            end
            rsp_hold = draw_gap(rsp_run, rsp_no_idle);
         end
         if (rsp_hold != 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !choke;
         end
      end
   end

   // one long hold-off on the answer side so queries back up behind it
   always @(posedge clock) begin : answer_choke
      if (reset) begin
         choke <= 1'b0;
      end else if (choke) begin
         if (choke_left == 0) choke <= 1'b0;
         else choke_left--;
      end else if (!choke_done && answers_seen >= 40) begin
         choke <= 1'b1;
         choke_left = CHOKE_CYCLES;
         choke_done = 1'b1;
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty table right after reset
      offer_query(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1);

      settle();
      write_csr(CSR_ROW_COUNT, 11'd4);
      gen_any_ver = 8'hAA;
      write_csr(CSR_ANY_VERSION, {3'b000, gen_any_ver});
      @(negedge clock);
      // "ABCD" / "ABC?" rows, each with a fixed and an any-version entry
      offer_load(10'd0, 64'd0, 32'h4142_4344, 8'h01, 16'h0000, 32'h0000_0000, 32'h0000_0000);
      offer_load(10'd1, 64'd1, 32'h4142_433F, 8'h01, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      offer_load(10'd2, 64'h8000_0000_0000_0000, 32'h4142_4344, 8'hAA,
                 16'h1234, 32'h5555_AAAA, 32'hAAAA_5555);
      offer_load(10'd3, 64'hFFFF_FFFF_FFFF_FFFF, 32'h4142_433F, 8'hAA,
                 16'h8001, 32'h0000_0001, 32'h8000_0000);
      offer_query(64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 8'd0, 1'b0);
      offer_query(64'd1, 32'h4142_4344, 8'h01, 1'b1);
      offer_query(64'd0, 32'h4142_4344, 8'h01, 1'b1);   // exact beats wildcard
      offer_query(64'd5, 32'h4142_4345, 8'h01, 1'b1);   // wildcard, same version
      offer_query(64'd0, 32'h4142_4344, 8'h00, 1'b1);   // exact, any version
      offer_query(64'd0, 32'h4142_4345, 8'hFF, 1'b1);   // wildcard, any version
      offer_query(64'd7, 32'h4142_4344, 8'h01, 1'b0);   // key miss without code
      offer_query(64'd0, 32'h5A5A_5A5A, 8'h01, 1'b1);   // no code match

      // unsorted keys and a tie on rank
      settle();
      write_csr(CSR_ROW_COUNT, 11'd3);
      @(negedge clock);
      offer_load(10'd0, 64'd9, 32'h5151_5151, 8'h02, 16'h0001, 32'h0000_0010, 32'h0000_0020);
      offer_load(10'd1, 64'd3, 32'h4142_4344, 8'h05, 16'h0002, 32'h0000_0030, 32'h0000_0040);
      offer_load(10'd2, 64'd5, 32'h5151_5151, 8'h02, 16'h0003, 32'h0000_0050, 32'h0000_0060);
      offer_query(64'd3, 32'd0, 8'd0, 1'b0);
      offer_query(64'd9, 32'd0, 8'd0, 1'b0);            // present but out of order
      offer_query(64'd0, 32'h5151_5151, 8'h02, 1'b1);   // first of two equal rows

      while (items_pushed < ITEM_TARGET - 20)
         table_phase(($urandom_range(0, 9) == 0) ? 11'd0 : 11'($urandom_range(1, 24)),
                     $urandom_range(8, 30), 1'b1);

      clamp_phase();

      settle();
      repeat (40) @(negedge clock);
      if (mismatches == 0 && answers_due.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
